// File: rtl/pairing_learn_mode_controller_core_macros.svh
// ---------------------------------------------------------------------------
// pairing learn mode controller assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in rst
// ---------------------------------------------------------------------------
`ifndef PAIRING_LEARN_MODE_CONTROLLER_CORE_MACROS_SVH
`define PAIRING_LEARN_MODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define PLMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plmc assertion failed");

// next-cycle implication
`define PLMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plmc assertion failed");

`endif

// File: rtl/plmc_pkg.sv
// ---------------------------------------------------------------------------
// plmc_pkg
// types and constants of the pairing learn mode controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package plmc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_PRESS_WINDOW = 3'd0,
    REG_LONG_HOLD    = 3'd1,
    REG_MODE_TIMEOUT = 3'd2,
    REG_BLINK_HALF   = 3'd3,
    REG_MIN_PRESS    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_REPLACE = 2'd2
  } mode_t;

  localparam logic [9:0]  PRESS_WINDOW_RST = 10'd350;
  localparam logic [9:0]  LONG_HOLD_RST    = 10'd300;
  localparam logic [12:0] MODE_TIMEOUT_RST = 13'd6000;
  localparam logic [5:0]  BLINK_HALF_RST   = 6'd30;
  localparam logic [5:0]  MIN_PRESS_RST    = 6'd3;

  localparam logic [9:0] HOLD_MAX  = 10'd1023;
  localparam logic [7:0] PRESS_MAX = 8'd255;

  typedef struct packed {
    logic [9:0]  press_window_ticks;
    logic [9:0]  long_hold_ticks;
    logic [12:0] mode_timeout_ticks;
    logic [5:0]  blink_half_ticks;
    logic [5:0]  min_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic        tick;
    logic        button_released;
    logic        id_received;
    logic        id_already_known;
    logic [23:0] received_id;
  } in_t;

  typedef struct packed {
    logic        led_on;
    logic        beep_pulse;
    logic        write_enable;
    logic [7:0]  write_index;
    logic [23:0] write_id;
    logic [8:0]  id_count;
    mode_t       learn_mode;
  } res_t;

endpackage

// File: rtl/plmc_if.sv
// ---------------------------------------------------------------------------
// plmc interfaces
// valid/ready channels for input words and result words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface plmc_in_if;
  logic        valid;
  logic        ready;
  logic        tick;
  logic        button_released;
  logic        id_received;
  logic        id_already_known;
  logic [23:0] received_id;

  modport source (
    output valid, tick, button_released, id_received, id_already_known, received_id,
    input  ready
  );
  modport sink (
    input  valid, tick, button_released, id_received, id_already_known, received_id,
    output ready
  );
endinterface

interface plmc_out_if;
  logic        valid;
  logic        ready;
  logic        led_on;
  logic        beep_pulse;
  logic        write_enable;
  logic [7:0]  write_index;
  logic [23:0] write_id;
  logic [8:0]  id_count;
  logic [1:0]  learn_mode;

  modport source (
    output valid, led_on, beep_pulse, write_enable, write_index, write_id, id_count,
           learn_mode,
    input  ready
  );
  modport sink (
    input  valid, led_on, beep_pulse, write_enable, write_index, write_id, id_count,
           learn_mode,
    output ready
  );
endinterface

// File: rtl/plmc_apb_regs.sv
// ---------------------------------------------------------------------------
// plmc_apb_regs
// apb configuration registers with read back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plmc_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plmc_pkg::ADDR_W-1:0] paddr,
  input  logic [plmc_pkg::DATA_W-1:0] pwdata,
  output logic [plmc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output plmc_pkg::cfg_t              cfg
);

  plmc_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = plmc_pkg::reg_idx_t'(paddr[plmc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_window_ticks <= plmc_pkg::PRESS_WINDOW_RST;
      cfg.long_hold_ticks    <= plmc_pkg::LONG_HOLD_RST;
      cfg.mode_timeout_ticks <= plmc_pkg::MODE_TIMEOUT_RST;
      cfg.blink_half_ticks   <= plmc_pkg::BLINK_HALF_RST;
      cfg.min_press_ticks    <= plmc_pkg::MIN_PRESS_RST;
    end else if (wr) begin
      case (idx)
        plmc_pkg::REG_PRESS_WINDOW: cfg.press_window_ticks <= pwdata[9:0];
        plmc_pkg::REG_LONG_HOLD:    cfg.long_hold_ticks    <= pwdata[9:0];
        plmc_pkg::REG_MODE_TIMEOUT: cfg.mode_timeout_ticks <= pwdata[12:0];
        plmc_pkg::REG_BLINK_HALF:   cfg.blink_half_ticks   <= pwdata[5:0];
        plmc_pkg::REG_MIN_PRESS:    cfg.min_press_ticks    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      plmc_pkg::REG_PRESS_WINDOW: prdata = {22'd0, cfg.press_window_ticks};
      plmc_pkg::REG_LONG_HOLD:    prdata = {22'd0, cfg.long_hold_ticks};
      plmc_pkg::REG_MODE_TIMEOUT: prdata = {19'd0, cfg.mode_timeout_ticks};
      plmc_pkg::REG_BLINK_HALF:   prdata = {26'd0, cfg.blink_half_ticks};
      plmc_pkg::REG_MIN_PRESS:    prdata = {26'd0, cfg.min_press_ticks};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: rtl/plmc_step.sv
// ---------------------------------------------------------------------------
// plmc_step
// controller state and one-tick update: button timing, modes, blink, id store
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module plmc_step #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  plmc_pkg::in_t  item,
  input  plmc_pkg::cfg_t cfg,
  output plmc_pkg::res_t res
);

  localparam logic [8:0] DEPTH_C = 9'(TABLE_DEPTH);

  logic [9:0]  window_timer, window_timer_next;
  logic [9:0]  hold_time, hold_time_next;
  logic [7:0]  press_count, press_count_next;
  logic        add_mode, add_mode_next;
  logic        replace_mode, replace_mode_next;
  logic        replace_first, replace_first_next;
  logic        exit_seen, exit_seen_next;
  logic [5:0]  blink_timer, blink_timer_next;
  logic        led_level, led_level_next;
  logic [12:0] exit_timer, exit_timer_next;
  logic [8:0]  stored_count, stored_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_timer  <= '0;
      hold_time     <= '0;
      press_count   <= '0;
      add_mode      <= 1'b0;
      replace_mode  <= 1'b0;
      replace_first <= 1'b0;
      exit_seen     <= 1'b0;
      blink_timer   <= '0;
      led_level     <= 1'b0;
      exit_timer    <= '0;
      stored_count  <= '0;
    end else if (en) begin
      window_timer  <= window_timer_next;
      hold_time     <= hold_time_next;
      press_count   <= press_count_next;
      add_mode      <= add_mode_next;
      replace_mode  <= replace_mode_next;
      replace_first <= replace_first_next;
      exit_seen     <= exit_seen_next;
      blink_timer   <= blink_timer_next;
      led_level     <= led_level_next;
      exit_timer    <= exit_timer_next;
      stored_count  <= stored_count_next;
    end
  end

  always_comb begin
    logic [8:0] slot;
    window_timer_next  = window_timer;
    hold_time_next     = hold_time;
    press_count_next   = press_count;
    add_mode_next      = add_mode;
    replace_mode_next  = replace_mode;
    replace_first_next = replace_first;
    exit_seen_next     = exit_seen;
    blink_timer_next   = blink_timer;
    led_level_next     = led_level;
    exit_timer_next    = exit_timer;
    stored_count_next  = stored_count;
    res.beep_pulse     = 1'b0;
    res.write_enable   = 1'b0;
    res.write_index    = '0;
    res.write_id       = '0;
    slot               = '0;

    if (item.tick) begin
      // press window
      if (window_timer != '0) begin
        window_timer_next = window_timer - 10'd1;
      end else if (!add_mode && !replace_mode) begin
        hold_time_next   = '0;
        press_count_next = '0;
      end

      // button level
      if (!item.button_released) begin
        if (hold_time_next != plmc_pkg::HOLD_MAX) begin
          hold_time_next = hold_time_next + 10'd1;
        end
        window_timer_next = cfg.press_window_ticks;
        if (press_count_next >= 8'd2) begin
          add_mode_next   = 1'b1;
          exit_timer_next = cfg.mode_timeout_ticks;
        end
        if ((replace_mode_next && press_count_next >= 8'd1) ||
            (add_mode_next && press_count_next >= 8'd3)) begin
          exit_seen_next    = 1'b1;
          add_mode_next     = 1'b0;
          replace_mode_next = 1'b0;
          led_level_next    = 1'b0;
        end
      end else begin
        if (hold_time_next > {4'd0, cfg.min_press_ticks} &&
            press_count_next != plmc_pkg::PRESS_MAX) begin
          press_count_next = press_count_next + 8'd1;
        end
        if (exit_seen_next) begin
          exit_seen_next   = 1'b0;
          press_count_next = '0;
        end
        hold_time_next = '0;
      end

      // long hold
      if (hold_time_next >= cfg.long_hold_ticks) begin
        hold_time_next     = '0;
        replace_mode_next  = 1'b1;
        replace_first_next = 1'b1;
        exit_timer_next    = cfg.mode_timeout_ticks;
      end

      // in a mode: blink, store, timeout
      if (add_mode_next || replace_mode_next) begin
        blink_timer_next = blink_timer_next + 6'd1;
        if (blink_timer_next >= cfg.blink_half_ticks) begin
          blink_timer_next = '0;
          led_level_next   = !led_level_next;
        end
        if (item.id_received && !item.id_already_known) begin
          res.beep_pulse  = 1'b1;
          exit_timer_next = cfg.mode_timeout_ticks;
          if (!add_mode_next && replace_first_next) begin
            replace_first_next = 1'b0;
            stored_count_next  = '0;
          end
          if (stored_count_next < DEPTH_C) begin
            stored_count_next = stored_count_next + 9'd1;
          end
          slot             = stored_count_next - 9'd1;
          res.write_enable = 1'b1;
          res.write_index  = slot[7:0];
          res.write_id     = item.received_id;
        end
        if (exit_timer_next != '0) begin
          exit_timer_next = exit_timer_next - 13'd1;
        end else begin
          exit_seen_next    = 1'b1;
          add_mode_next     = 1'b0;
          replace_mode_next = 1'b0;
          led_level_next    = 1'b0;
        end
      end
    end

    res.led_on   = led_level_next;
    res.id_count = stored_count_next;
    if (add_mode_next) begin
      res.learn_mode = plmc_pkg::MODE_ADD;
    end else if (replace_mode_next) begin
      res.learn_mode = plmc_pkg::MODE_REPLACE;
    end else begin
      res.learn_mode = plmc_pkg::MODE_IDLE;
    end
  end

endmodule

// File: rtl/pairing_learn_mode_controller_core.sv
// ---------------------------------------------------------------------------
// pairing_learn_mode_controller_core
// receiver pairing controller: learn button timing, add and replace modes,
// led blink, new id write requests
// ---------------------------------------------------------------------------
// One word is accepted per clock unless stalled and gives one result word: the
// input word is registered, the whole tick update runs in one pass of plmc_step
// against the controller state, and the result is registered. A word with tick
// low leaves the state unchanged and reports it. in ready follows out ready
// combinationally when both stages are full. Write configuration over the apb
// port only while no word is in flight; the core does not enforce this.
`timescale 1ns / 1ps

`include "pairing_learn_mode_controller_core_macros.svh"

module pairing_learn_mode_controller_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  plmc_in_if.sink                     in_ch,
  plmc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plmc_pkg::ADDR_W-1:0] paddr,
  input  logic [plmc_pkg::DATA_W-1:0] pwdata,
  output logic [plmc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  plmc_pkg::cfg_t cfg;
  plmc_pkg::in_t  in_q;
  plmc_pkg::res_t res;
  plmc_pkg::res_t out_q;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           advance;
  logic           in_acc;

  plmc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plmc_step #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q.tick             <= in_ch.tick;
      in_q.button_released  <= in_ch.button_released;
      in_q.id_received      <= in_ch.id_received;
      in_q.id_already_known <= in_ch.id_already_known;
      in_q.received_id      <= in_ch.received_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.led_on       = out_q.led_on;
  assign out_ch.beep_pulse   = out_q.beep_pulse;
  assign out_ch.write_enable = out_q.write_enable;
  assign out_ch.write_index  = out_q.write_index;
  assign out_ch.write_id     = out_q.write_id;
  assign out_ch.id_count     = out_q.id_count;
  assign out_ch.learn_mode   = out_q.learn_mode;

  `PLMC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
  `PLMC_ASSERT_IMP(a_write_beeps, out_valid_q && out_q.write_enable, out_q.beep_pulse)
  `PLMC_ASSERT_IMP(a_write_slot, out_valid_q && out_q.write_enable,
    out_q.id_count != 9'd0 && out_q.write_index == 8'(out_q.id_count - 9'd1))
  `PLMC_ASSERT_IMP(a_idle_write_clear, out_valid_q && !out_q.write_enable,
    out_q.write_index == 8'd0 && out_q.write_id == 24'd0)
  `PLMC_ASSERT_IMP(a_count_bound, out_valid_q, out_q.id_count <= 9'(TABLE_DEPTH))

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// pairing learn mode controller core: words are driven and results checked
// against a cycle-free prediction of the tick update. Covers short presses,
// long holds, add and replace modes, timeouts, table saturation, register
// extremes, random gaps on both channels and a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import plmc_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int LIMIT_CYCLES   = 300000;
  localparam int HOLDOFF_CYCLES = 300;

  class pairing_tracker;
    cfg_t       cfg;
    bit [9:0]   gap_left;
    bit [9:0]   held_for;
    bit [7:0]   clicks;
    bit         adding;
    bit         replacing;
    bit         clear_on_next;
    bit         left_mode;
    bit [5:0]   blink_cnt;
    bit         lamp;
    bit [12:0]  idle_left;
    bit [8:0]   id_total;
    res_t       awaited[$];
    int         errors;
    int         words_in;
    int         words_out;
    int         id_writes;
    int         full_writes;
    int         add_words;
    int         replace_words;
    int         dual_words;

    function new();
      cfg.press_window_ticks = PRESS_WINDOW_RST;
      cfg.long_hold_ticks    = LONG_HOLD_RST;
      cfg.mode_timeout_ticks = MODE_TIMEOUT_RST;
      cfg.blink_half_ticks   = BLINK_HALF_RST;
      cfg.min_press_ticks    = MIN_PRESS_RST;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_PRESS_WINDOW: cfg.press_window_ticks = v[9:0];
        REG_LONG_HOLD:    cfg.long_hold_ticks    = v[9:0];
        REG_MODE_TIMEOUT: cfg.mode_timeout_ticks = v[12:0];
        REG_BLINK_HALF:   cfg.blink_half_ticks   = v[5:0];
        REG_MIN_PRESS:    cfg.min_press_ticks    = v[5:0];
        default: ;
      endcase
    endfunction

    function void drop_mode();
      left_mode = 1'b1;
      adding    = 1'b0;
      replacing = 1'b0;
      lamp      = 1'b0;
    endfunction

    function void take_word(in_t w);
      res_t r;
      r = '0;
      r.learn_mode = MODE_IDLE;
      words_in++;
      if (w.tick) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!adding && !replacing) begin
          held_for = 0;
          clicks   = 0;
        end
        if (!w.button_released) begin
          if (held_for < HOLD_MAX) held_for++;
          gap_left = cfg.press_window_ticks;
          if (clicks >= 2) begin
            adding    = 1'b1;
            idle_left = cfg.mode_timeout_ticks;
          end
          if ((replacing && clicks >= 1) || (adding && clicks >= 3)) drop_mode();
        end else begin
          if (held_for > cfg.min_press_ticks && clicks < PRESS_MAX) clicks++;
          if (left_mode) begin
            left_mode = 1'b0;
            clicks    = 0;
          end
          held_for = 0;
        end
        if (held_for >= cfg.long_hold_ticks) begin
          held_for      = 0;
          replacing     = 1'b1;
          clear_on_next = 1'b1;
          idle_left     = cfg.mode_timeout_ticks;
        end
        if (adding || replacing) begin
          blink_cnt++;
          if (blink_cnt >= cfg.blink_half_ticks) begin
            blink_cnt = 0;
            lamp      = !lamp;
          end
          if (w.id_received && !w.id_already_known) begin
            r.beep_pulse = 1'b1;
            idle_left    = cfg.mode_timeout_ticks;
            if (!adding && clear_on_next) begin
              clear_on_next = 1'b0;
              id_total      = 0;
            end
            if (id_total < TABLE_DEPTH) id_total++;
            else full_writes++;
            r.write_enable = 1'b1;
            r.write_index  = 8'(id_total - 1);
            r.write_id     = w.received_id;
            id_writes++;
          end
          if (idle_left != 0) idle_left--;
          else drop_mode();
        end
      end
      r.led_on   = lamp;
      r.id_count = id_total;
      if (adding) r.learn_mode = MODE_ADD;
      else if (replacing) r.learn_mode = MODE_REPLACE;
      if (adding && replacing) dual_words++;
      else if (adding) add_words++;
      else if (replacing) replace_words++;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("error at %0t: %s", $realtime, msg);
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got 0x%0h want 0x%0h", words_out, name, got, want));
    endtask

    task match_word(res_t got);
      res_t want;
      words_out++;
      if (awaited.size() == 0) begin
        report("result word with no input word waiting for it");
        return;
      end
      want = awaited.pop_front();
      field_check("led_on", got.led_on, want.led_on);
      field_check("beep_pulse", got.beep_pulse, want.beep_pulse);
      field_check("write_enable", got.write_enable, want.write_enable);
      field_check("write_index", got.write_index, want.write_index);
      field_check("write_id", got.write_id, want.write_id);
      field_check("id_count", got.id_count, want.id_count);
      field_check("learn_mode", got.learn_mode, want.learn_mode);
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 stall_all;
  logic                 holdoff_go;
  int                   src_idle_pct;
  int                   snk_stall_pct;
  int                   ticks_sent;
  int                   settings_used;
  int                   cycle_count;
  pairing_tracker       tracker;

  plmc_in_if  word_in ();
  plmc_out_if word_out ();

  pairing_learn_mode_controller_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (word_in),
    .out_ch (word_out),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("pairing_learn_mode_controller_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    res_t got;
    if (!rst) begin
      if (word_in.valid && word_in.ready)
        tracker.take_word(in_t'{word_in.tick, word_in.button_released, word_in.id_received,
                                word_in.id_already_known, word_in.received_id});
      if (word_out.valid && word_out.ready) begin
        got.led_on       = word_out.led_on;
        got.beep_pulse   = word_out.beep_pulse;
        got.write_enable = word_out.write_enable;
        got.write_index  = word_out.write_index;
        got.write_id     = word_out.write_id;
        got.id_count     = word_out.id_count;
        got.learn_mode   = mode_t'(word_out.learn_mode);
        tracker.match_word(got);
      end
    end
  end

  // output side ready, with the long stall forced by the hold-off process
  initial begin
    word_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      word_out.ready <= !stall_all && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    stall_all = 1'b0;
    wait (holdoff_go);
    @(negedge clk);
    stall_all <= 1'b1;
    for (int n = 0; n < HOLDOFF_CYCLES; n++) @(negedge clk);
    stall_all <= 1'b0;
  end

  task automatic send_word(in_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      word_in.valid <= 1'b0;
      @(negedge clk);
    end
    word_in.valid            <= 1'b1;
    word_in.tick             <= w.tick;
    word_in.button_released  <= w.button_released;
    word_in.id_received      <= w.id_received;
    word_in.id_already_known <= w.id_already_known;
    word_in.received_id      <= w.received_id;
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
    if (w.tick) ticks_sent++;
    @(negedge clk);
  endtask

  task automatic one_tick(bit rel, int id_pct, int known_pct);
    in_t w;
    if ($urandom_range(99) < 8) begin
      w = in_t'($urandom);
      w.tick = 1'b0;
      send_word(w);
    end
    w.tick             = 1'b1;
    w.button_released  = rel;
    w.id_received      = ($urandom_range(99) < id_pct);
    w.id_already_known = ($urandom_range(99) < known_pct);
    w.received_id      = 24'($urandom);
    send_word(w);
  endtask

  task automatic hold_button(int len, int id_pct);
    repeat (len) one_tick(1'b0, id_pct, 30);
  endtask

  task automatic rest(int len, int id_pct);
    repeat (len) one_tick(1'b1, id_pct, 30);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_regs(int pw, int lh, int to, int bh, int mp);
    write_reg(REG_PRESS_WINDOW, pw);
    write_reg(REG_LONG_HOLD, lh);
    write_reg(REG_MODE_TIMEOUT, to);
    write_reg(REG_BLINK_HALF, bh);
    write_reg(REG_MIN_PRESS, mp);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic settle();
    word_in.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed press sequences, the rest quiet stretches with id traffic
  task automatic random_run(int n);
    int stop_at;
    int pick;
    int lh;
    int mp;
    int gap_max;
    stop_at = ticks_sent + n;
    lh      = (tracker.cfg.long_hold_ticks > 60) ? 60 : tracker.cfg.long_hold_ticks;
    mp      = (tracker.cfg.min_press_ticks > 40) ? 40 : tracker.cfg.min_press_ticks;
    gap_max = (tracker.cfg.press_window_ticks > 28) ? 30 : tracker.cfg.press_window_ticks + 2;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat (3) begin
          hold_button($urandom_range(1, mp + 3), 40);
          rest($urandom_range(1, gap_max), 40);
        end
      end else if (pick < 60) begin
        hold_button($urandom_range((lh > 1) ? lh - 1 : 1, lh + 2), 40);
        rest($urandom_range(1, 10), 40);
      end else if (pick < 75) begin
        repeat (2) begin
          hold_button($urandom_range(1, mp + 3), 40);
          rest($urandom_range(1, gap_max), 40);
        end
        hold_button($urandom_range((lh > 1) ? lh : 1, lh + 2), 40);
        rest($urandom_range(1, 10), 40);
      end else begin
        rest($urandom_range(1, 40), 40);
      end
    end
  endtask

  task automatic fill_table();
    rest(60, 0);
    settle();
    set_regs(20, 1023, 8191, 63, 2);
    repeat (2) begin
      hold_button(4, 0);
      rest(2, 0);
    end
    hold_button(1, 0);
    repeat (300) one_tick(1'b1, 100, 10);
  endtask

  initial begin
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    holdoff_go               = 1'b0;
    src_idle_pct             = 0;
    snk_stall_pct            = 0;
    ticks_sent               = 0;
    settings_used            = 0;
    word_in.valid            = 1'b0;
    word_in.tick             = 1'b0;
    word_in.button_released  = 1'b1;
    word_in.id_received      = 1'b0;
    word_in.id_already_known = 1'b0;
    word_in.received_id      = '0;
    tracker                  = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no tick, ids outside a mode
    send_word(in_t'{1'b0, 1'b1, 1'b1, 1'b0, 24'hffffff});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b0, 24'h000000});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b1, 24'hffffff});
    settle();
    set_regs(10, 4, 15, 2, 1);
    // two short presses, then a long hold sets both modes
    repeat (2) begin
      send_word(in_t'{1'b1, 1'b0, 1'b0, 1'b0, 24'h0});
      send_word(in_t'{1'b1, 1'b0, 1'b0, 1'b0, 24'h0});
      send_word(in_t'{1'b1, 1'b1, 1'b0, 1'b0, 24'h0});
    end
    repeat (4) send_word(in_t'{1'b1, 1'b0, 1'b0, 1'b0, 24'h0});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b0, 24'h000000});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b0, 24'hffffff});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b1, 24'haaaaaa});
    // press in a mode leaves it
    send_word(in_t'{1'b1, 1'b0, 1'b0, 1'b0, 24'h0});
    send_word(in_t'{1'b1, 1'b1, 1'b0, 1'b0, 24'h0});
    // long hold alone enters replace mode, first new id clears the count
    repeat (4) send_word(in_t'{1'b1, 1'b0, 1'b0, 1'b0, 24'h0});
    send_word(in_t'{1'b1, 1'b1, 1'b0, 1'b0, 24'h0});
    send_word(in_t'{1'b1, 1'b1, 1'b1, 1'b0, 24'h555555});
    send_word(in_t'{1'b0, 1'b0, 1'b1, 1'b0, 24'h123456});
    settle();

    set_regs(12, 10, 40, 3, 2);
    random_run(50);
    settle();

    src_idle_pct = 80;
    set_regs(8, 6, 25, 1, 0);
    holdoff_go = 1'b1;
    random_run(50);

    src_idle_pct  = 0;
    snk_stall_pct = 80;
    fill_table();
    settle();

    src_idle_pct  = 36;
    snk_stall_pct = 36;
    set_regs(1, 1, 1, 1, 0);
    random_run(40);
    settle();

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_regs(0, 0, 0, 0, 0);
    random_run(30);
    settle();

    snk_stall_pct = 80;
    set_regs(1023, 1023, 8191, 63, 63);
    random_run(30);
    settle();

    src_idle_pct  = 80;
    snk_stall_pct = 0;
    set_regs(15, 8, 60, 4, 3);
    random_run(40);
    settle();

    $display("covered %0d input words, %0d result words, %0d register settings",
             tracker.words_in, tracker.words_out, settings_used);
    $display("%0d id writes (%0d at a full table); add %0d, replace %0d, both %0d words",
             tracker.id_writes, tracker.full_writes, tracker.add_words,
             tracker.replace_words, tracker.dual_words);
    if (tracker.errors == 0) begin
      $display("pairing_learn_mode_controller_core: match");
    end else begin
      $display("pairing_learn_mode_controller_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/plmc_pkg.sv
rtl/plmc_if.sv
rtl/plmc_apb_regs.sv
rtl/plmc_step.sv
rtl/pairing_learn_mode_controller_core.sv
dv/testbench.sv
